### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the converter checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PFC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// expression must never be true outside reset
`define PFC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error(msg);

`endif

### rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, constants and saturating helpers of the frame converter
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int WD         = 64;
	localparam int FRAC       = 16;
	localparam int DIV_BITS   = WD + FRAC;
	localparam int DIV_LAT    = DIV_BITS + 2;
	localparam int MUL_LAT    = 3;
	localparam int SQRT_STEPS = WD / 2;
	localparam int REG_W      = 31;

	typedef logic signed [WD-1:0] fix_t;
	typedef logic [WD-1:0]        mag_t;
	typedef logic [1:0]           fault_t;
	typedef logic [1:0]           reg_idx_t;

	localparam fix_t ONE   = 64'sd1 <<< FRAC;
	localparam fix_t MAX_S = {1'b0, {(WD-1){1'b1}}};
	localparam fix_t MIN_S = {1'b1, {(WD-1){1'b0}}};

	localparam fault_t FAULT_NONE = 2'd0;
	localparam fault_t FAULT_ROOT = 2'd1;
	localparam fault_t FAULT_DIVZ = 2'd2;

	localparam reg_idx_t REG_UNIT_X    = 2'd0;
	localparam reg_idx_t REG_UNIT_Y    = 2'd1;
	localparam reg_idx_t REG_REF_GAMMA = 2'd2;

	localparam logic [REG_W-1:0] REG_RESET = 31'd65536;

	function automatic mag_t magn(input fix_t a);
		return a[WD-1] ? (mag_t'(0) - mag_t'(a)) : mag_t'(a);
	endfunction

	function automatic fix_t from_sm(input logic neg, input mag_t m);
		if (m[WD-1])
			return neg ? MIN_S : MAX_S;
		return neg ? fix_t'(mag_t'(0) - m) : fix_t'(m);
	endfunction

	function automatic fix_t add_s(input fix_t a, input fix_t b);
		logic [WD:0] s;
		s = {a[WD-1], a} + {b[WD-1], b};
		if (s[WD] != s[WD-1])
			return s[WD] ? MIN_S : MAX_S;
		return fix_t'(s[WD-1:0]);
	endfunction

	function automatic fix_t sub_s(input fix_t a, input fix_t b);
		logic [WD:0] s;
		s = {a[WD-1], a} - {b[WD-1], b};
		if (s[WD] != s[WD-1])
			return s[WD] ? MIN_S : MAX_S;
		return fix_t'(s[WD-1:0]);
	endfunction

endpackage

### rtl/pfc_mul.sv
// ----------------------------------------------------------------------------
// pfc_mul
// pipelined saturating q48.16 multiplier, four 32x32 partial products
// ----------------------------------------------------------------------------
module pfc_mul (
	input  logic          clk,
	input  logic          en,
	input  pfc_pkg::fix_t a,
	input  pfc_pkg::fix_t b,
	output pfc_pkg::fix_t p
);

	pfc_pkg::mag_t ua_s1, ub_s1;
	logic          neg_s1, neg_s2;
	logic [63:0]   p00_s2, p01_s2, p10_s2, p11_s2;
	pfc_pkg::fix_t p_s3;
	logic [127:0]  full;
	pfc_pkg::mag_t m;

	always_comb begin
		full = 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32)
			+ (128'(p11_s2) << 64);
		m = (|full[127:112]) ? '1 : full[79:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= pfc_pkg::magn(a);
			ub_s1  <= pfc_pkg::magn(b);
			neg_s1 <= a[63] ^ b[63];
			p00_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[31:0]);
			p01_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[63:32]);
			p10_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[31:0]);
			p11_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[63:32]);
			neg_s2 <= neg_s1;
			p_s3   <= pfc_pkg::from_sm(neg_s2, m);
		end
	end

	assign p = p_s3;

endmodule

### rtl/pfc_div.sv
// ----------------------------------------------------------------------------
// pfc_div
// pipelined restoring q48.16 divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pfc_div (
	input  logic          clk,
	input  logic          en,
	input  pfc_pkg::fix_t a,
	input  pfc_pkg::fix_t b,
	output pfc_pkg::fix_t q,
	output logic          dz
);

	localparam int NB = pfc_pkg::DIV_BITS;
	localparam int W  = pfc_pkg::WD;

	logic [W-1:0]  rem_s [0:NB];
	logic [NB-1:0] num_s [0:NB];
	logic [W-1:0]  ub_s  [0:NB];
	logic          neg_s [0:NB];
	logic          dz_s  [0:NB];
	logic          apos_s[0:NB];
	logic          aneg_s[0:NB];
	logic [W-1:0]  rem_n [1:NB];
	logic [NB-1:0] num_n [1:NB];
	pfc_pkg::fix_t q_q;
	logic          dz_q;
	pfc_pkg::fix_t res;

	always_comb begin
		for (int i = 1; i <= NB; i++) begin
			logic [W:0] t;
			logic [W:0] d;
			logic       ge;
			t  = {rem_s[i-1], num_s[i-1][NB-1]};
			d  = t - {1'b0, ub_s[i-1]};
			ge = t >= {1'b0, ub_s[i-1]};
			rem_n[i] = ge ? d[W-1:0] : t[W-1:0];
			num_n[i] = {num_s[i-1][NB-2:0], ge};
		end
	end

	always_comb begin
		if (dz_s[NB])
			res = apos_s[NB] ? pfc_pkg::MAX_S : (aneg_s[NB] ? pfc_pkg::MIN_S : '0);
		else if (|num_s[NB][NB-1:W])
			res = pfc_pkg::from_sm(neg_s[NB], '1);
		else
			res = pfc_pkg::from_sm(neg_s[NB], num_s[NB][W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			num_s[0]  <= {pfc_pkg::magn(a), {pfc_pkg::FRAC{1'b0}}};
			ub_s[0]   <= pfc_pkg::magn(b);
			neg_s[0]  <= a[W-1] ^ b[W-1];
			dz_s[0]   <= (b == '0);
			apos_s[0] <= !a[W-1] && (a != '0);
			aneg_s[0] <= a[W-1];
			for (int i = 1; i <= NB; i++) begin
				rem_s[i]  <= rem_n[i];
				num_s[i]  <= num_n[i];
				ub_s[i]   <= ub_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				dz_s[i]   <= dz_s[i-1];
				apos_s[i] <= apos_s[i-1];
				aneg_s[i] <= aneg_s[i-1];
			end
			q_q  <= res;
			dz_q <= dz_s[NB];
		end
	end

	assign q  = q_q;
	assign dz = dz_q;

endmodule

### rtl/particle_frame_converter_unit.sv
// ----------------------------------------------------------------------------
// particle_frame_converter_unit
// streams particles and converts them between fixed-z and fixed-t frames
// ----------------------------------------------------------------------------
// input stream: s_tdata carries the six coordinates, s_tuser the target frame
// (0 fixed-t, 1 fixed-z), s_tlast marks the last particle of a batch.
// output stream: m_tdata carries the three converted coordinates, m_tuser the
// converted flag and the fault code, m_tlast copies the batch mark.
// throughput: one particle per cycle while the receiver does not stall, all units fully pipelined.
// the path from input transfer to output valid runs through the chain
// reciprocal divide, two multiplies, 32-step square root, multiply, divide
// and the final divide (each divider computes one quotient bit per stage).
// the frame flag flips when a converting particle with tlast is accepted,
// so a batch boundary takes effect for the very next particle.
// reset clears the pipeline, sets the frame to fixed-z and loads the unit
// registers and reference gamma with 1.0.
// a stalled receiver freezes the whole pipeline and drops s_tready; nothing
// in flight is lost or repeated.
// configuration writes are taken at any time, but only while no particle
// is in flight do they give defined results.
// ----------------------------------------------------------------------------
module particle_frame_converter_unit #(
	parameter  int COORD_WIDTH = 32,
	localparam int IN_W        = ((6 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W       = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // pos_x, mom_x, pos_y, mom_y, pos_long, energy_coord
	input  logic             s_tuser,   // opcode
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // pos_x_out, pos_y_out, pos_long_out
	output logic [2:0]       m_tuser,   // converted, fault
	output logic             m_tlast,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [30:0]      cfg_wdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int D     = pfc_pkg::DIV_LAT;
	localparam int M     = pfc_pkg::MUL_LAT;
	localparam int NQ    = pfc_pkg::SQRT_STEPS;
	localparam int SDL   = D - 2;
	localparam int NARG  = D + 2 * M + 1;
	localparam int T2    = 2 * D + 3 * M + NQ + 2;
	localparam int MLEN  = T2 + D;
	localparam int T3    = MLEN + 1;
	localparam int MDL   = D - M - 1;

	localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] lg;
		logic                 to_z;
		logic                 last;
		logic                 conv;
		logic                 rdz;
		logic                 narg;
		logic                 fdz;
	} meta_t;

	function automatic logic [CW-1:0] pack(input pfc_pkg::fix_t v);
		if (v > CMAX)
			return CMAX[CW-1:0];
		if (v < CMIN)
			return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	logic [30:0] unit_x_q, unit_y_q, ref_gamma_q;
	logic        frame_q;
	logic        en, conv_in;
	logic        v_s [0:T3];

	meta_t                meta_s [0:MLEN];
	meta_t                meta_n [1:MLEN];
	meta_t                entry;
	logic signed [CW-1:0] xp_s0, yp_s0, e_s0;
	pfc_pkg::fix_t        ux64, uy64, g64;

	pfc_pkg::fix_t rcp, mxx, myy, rr, prod, gb, fq;
	logic          rdz1, fdz1;
	pfc_pkg::fix_t sa_s, myy_s, arg;
	pfc_pkg::fix_t s_d [0:SDL];

	pfc_pkg::mag_t sq_n_s [0:NQ];
	pfc_pkg::mag_t sq_r_s [0:NQ];
	pfc_pkg::mag_t sq_n_n [1:NQ];
	pfc_pkg::mag_t sq_r_n [1:NQ];

	pfc_pkg::fix_t f_q, fx, fy, flg;
	pfc_pkg::fix_t qx, qy, qlg, px, py, plg;
	logic          dzx, dzy, dzlg;
	pfc_pkg::fix_t mdx [0:MDL];
	pfc_pkg::fix_t mdy [0:MDL];
	pfc_pkg::fix_t mdl [0:MDL];

	meta_t            fin;
	pfc_pkg::fix_t    rx, ry, rlg;
	logic             dzany;
	pfc_pkg::fault_t  flt;
	logic [CW-1:0]    out_x_q, out_y_q, out_lg_q;
	logic             out_conv_q, out_last_q;
	pfc_pkg::fault_t  out_flt_q;

	assign en       = !v_s[T3] || m_tready;
	assign s_tready = en;
	assign conv_in  = s_tuser ? !frame_q : frame_q;

	assign ux64 = $signed(64'(unit_x_q));
	assign uy64 = $signed(64'(unit_y_q));
	assign g64  = $signed(64'(ref_gamma_q));

	always_comb begin
		entry      = '0;
		entry.x    = s_tdata[0 * CW +: CW];
		entry.y    = s_tdata[2 * CW +: CW];
		entry.lg   = s_tdata[4 * CW +: CW];
		entry.to_z = s_tuser;
		entry.last = s_tlast;
		entry.conv = conv_in;
	end

	// control: config registers, frame flag, valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_x_q    <= pfc_pkg::REG_RESET;
			unit_y_q    <= pfc_pkg::REG_RESET;
			ref_gamma_q <= pfc_pkg::REG_RESET;
			frame_q     <= 1'b1;
			for (int k = 0; k <= T3; k++)
				v_s[k] <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					pfc_pkg::REG_UNIT_X:    unit_x_q    <= cfg_wdata;
					pfc_pkg::REG_UNIT_Y:    unit_y_q    <= cfg_wdata;
					pfc_pkg::REG_REF_GAMMA: ref_gamma_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && en && conv_in && s_tlast)
				frame_q <= !frame_q;
			if (en) begin
				v_s[0] <= s_tvalid;
				for (int k = 1; k <= T3; k++)
					v_s[k] <= v_s[k-1];
			end
		end
	end

	// first leg: reciprocal of the energy term and transverse sum
	pfc_div u_div_rcp (
		.clk(clk), .en(en),
		.a(pfc_pkg::ONE), .b(pfc_pkg::sub_s(g64, 64'(e_s0))),
		.q(rcp), .dz(rdz1)
	);

	pfc_mul u_mul_xx (.clk(clk), .en(en), .a(64'(xp_s0)), .b(64'(xp_s0)), .p(mxx));
	pfc_mul u_mul_yy (.clk(clk), .en(en), .a(64'(yp_s0)), .b(64'(yp_s0)), .p(myy));

	pfc_mul u_mul_rr (.clk(clk), .en(en), .a(rcp), .b(rcp), .p(rr));
	pfc_mul u_mul_rs (.clk(clk), .en(en), .a(rr), .b(s_d[SDL]), .p(prod));

	assign arg = pfc_pkg::sub_s(pfc_pkg::ONE, prod);

	// square root, one result bit per stage
	always_comb begin
		for (int j = 1; j <= NQ; j++) begin
			pfc_pkg::mag_t bt;
			pfc_pkg::mag_t rb;
			bt = pfc_pkg::mag_t'(1) << (pfc_pkg::WD - 2 * j);
			rb = sq_r_s[j-1] + bt;
			if (sq_n_s[j-1] >= rb) begin
				sq_n_n[j] = sq_n_s[j-1] - rb;
				sq_r_n[j] = (sq_r_s[j-1] >> 1) + bt;
			end else begin
				sq_n_n[j] = sq_n_s[j-1];
				sq_r_n[j] = sq_r_s[j-1] >> 1;
			end
		end
	end

	pfc_mul u_mul_gb (
		.clk(clk), .en(en), .a(g64), .b($signed(sq_r_s[NQ])), .p(gb)
	);

	pfc_div u_div_f (.clk(clk), .en(en), .a(gb), .b(ux64), .q(fq), .dz(fdz1));

	// final leg: both directions in parallel, picked at the output
	assign fx  = 64'(meta_s[T2].x);
	assign fy  = 64'(meta_s[T2].y);
	assign flg = 64'(meta_s[T2].lg);

	pfc_div u_div_x  (.clk(clk), .en(en), .a(fx),  .b(ux64), .q(qx),  .dz(dzx));
	pfc_div u_div_y  (.clk(clk), .en(en), .a(fy),  .b(uy64), .q(qy),  .dz(dzy));
	pfc_div u_div_lg (.clk(clk), .en(en), .a(flg), .b(f_q),  .q(qlg), .dz(dzlg));

	pfc_mul u_mul_x  (.clk(clk), .en(en), .a(fx),  .b(ux64), .p(px));
	pfc_mul u_mul_y  (.clk(clk), .en(en), .a(fy),  .b(uy64), .p(py));
	pfc_mul u_mul_lg (.clk(clk), .en(en), .a(flg), .b(f_q),  .p(plg));

	always_comb begin
		fin = meta_s[MLEN];
		if (fin.to_z) begin
			rx    = mdx[MDL];
			ry    = mdy[MDL];
			rlg   = qlg;
			dzany = fin.rdz || fin.fdz || dzlg;
		end else begin
			rx    = qx;
			ry    = qy;
			rlg   = mdl[MDL];
			dzany = fin.rdz || fin.fdz || dzx || dzy;
		end
		if (!fin.conv) begin
			rx  = 64'(fin.x);
			ry  = 64'(fin.y);
			rlg = 64'(fin.lg);
			flt = pfc_pkg::FAULT_NONE;
		end else if (dzany) begin
			flt = pfc_pkg::FAULT_DIVZ;
		end else if (fin.narg) begin
			flt = pfc_pkg::FAULT_ROOT;
		end else begin
			flt = pfc_pkg::FAULT_NONE;
		end
	end

	// side flags join the item as it passes their stage
	always_comb begin
		for (int k = 1; k <= MLEN; k++)
			meta_n[k] = meta_s[k-1];
		meta_n[D+1].rdz   = rdz1;
		meta_n[NARG].narg = arg[63];
		meta_n[T2].fdz    = fdz1;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s0 <= s_tdata[1 * CW +: CW];
			yp_s0 <= s_tdata[3 * CW +: CW];
			e_s0  <= s_tdata[5 * CW +: CW];

			meta_s[0] <= entry;
			for (int k = 1; k <= MLEN; k++)
				meta_s[k] <= meta_n[k];

			sa_s   <= pfc_pkg::add_s(pfc_pkg::ONE, mxx);
			myy_s  <= myy;
			s_d[0] <= pfc_pkg::add_s(sa_s, myy_s);
			for (int k = 1; k <= SDL; k++)
				s_d[k] <= s_d[k-1];

			sq_n_s[0] <= arg[63] ? '0 : {arg[47:0], {pfc_pkg::FRAC{1'b0}}};
			sq_r_s[0] <= '0;
			for (int j = 1; j <= NQ; j++) begin
				sq_n_s[j] <= sq_n_n[j];
				sq_r_s[j] <= sq_r_n[j];
			end

			f_q <= pfc_pkg::sub_s('0, fq);

			mdx[0] <= px;
			mdy[0] <= py;
			mdl[0] <= plg;
			for (int k = 1; k <= MDL; k++) begin
				mdx[k] <= mdx[k-1];
				mdy[k] <= mdy[k-1];
				mdl[k] <= mdl[k-1];
			end

			out_x_q    <= pack(rx);
			out_y_q    <= pack(ry);
			out_lg_q   <= pack(rlg);
			out_conv_q <= fin.conv;
			out_flt_q  <= flt;
			out_last_q <= fin.last;
		end
	end

	assign m_tvalid = v_s[T3];
	assign m_tdata  = OUT_W'({out_lg_q, out_y_q, out_x_q});
	assign m_tuser  = {out_flt_q, out_conv_q};
	assign m_tlast  = out_last_q;

endmodule

### rtl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// port-level assertions for the particle frame converter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfc_checker #(
	parameter int DATA_W = 96
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [2:0]        m_tuser,
	input logic              m_tlast
);

	// stalled transfer holds its payload
	`PFC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "output changed while stalled")

	// a fault only comes with a converted item
	`PFC_ASSERT_NEVER(a_fault_conv, clk, arst_n, m_tvalid && !m_tuser[0] && m_tuser[2:1] != pfc_pkg::FAULT_NONE, "fault on pass-through item")

	// fault field carries a defined code
	`PFC_ASSERT_NEVER(a_fault_code, clk, arst_n, m_tvalid && m_tuser[2:1] != pfc_pkg::FAULT_NONE && m_tuser[2:1] != pfc_pkg::FAULT_ROOT && m_tuser[2:1] != pfc_pkg::FAULT_DIVZ, "undefined fault code")

	// empty output stage always takes input
	`PFC_ASSERT(a_ready_empty, clk, arst_n, !m_tvalid |-> s_tready, "input blocked with empty output")

	// a blocked result backs up to the input
	`PFC_ASSERT(a_stall_back, clk, arst_n, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")

endmodule

bind particle_frame_converter_unit pfc_checker #(.DATA_W(OUT_W)) u_pfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the particle frame converter: particles are streamed
// in with random gaps, each transfer is predicted in fixed point with a local
// frame flag and register copy, and every output transfer is compared in order
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q    = 64'sd65536;
	localparam int     LIMIT    = 400000;
	localparam int     DRAIN    = 320;

	typedef struct {
		logic               to_z;
		logic signed [31:0] x, xp, y, yp, lg, e;
		logic               last;
	} particle_t;

	typedef struct {
		logic [31:0]      x, y, lg;
		logic             conv;
		pfc_pkg::fault_t  fault;
		logic             last;
	} conv_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [191:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_wen = 1'b0;
	pfc_pkg::reg_idx_t cfg_index = pfc_pkg::REG_UNIT_X;
	logic [30:0] cfg_wdata = '0;

	logic [30:0] ux_q = 31'd65536, uy_q = 31'd65536, gamma_q = 31'd65536;
	logic frame_z_q = 1'b1;
	conv_out_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int max_gap = 15;
	int hold_len = 0;

	particle_frame_converter_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag(longint a);
		return a < 0 ? 64'd0 - 64'(a) : 64'(a);
	endfunction

	function automatic longint sat_sm(logic neg, logic [63:0] m);
		if (m[63])
			return neg ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		return neg ? longint'(64'd0 - m) : longint'(m);
	endfunction

	function automatic longint sat_sum(longint a, longint b, logic minus);
		logic signed [64:0] s;
		s = minus ? 65'(a) - 65'(b) : 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		return longint'(s[63:0]);
	endfunction

	// saturates on the top 16 product bits or a set bit 79, the rest above bit 79 drop out
	function automatic longint q_mul(longint a, longint b);
		logic [127:0] p;
		logic [63:0] m;
		p = {64'd0, mag(a)} * {64'd0, mag(b)};
		m = (p[127:112] != 0) ? '1 : p[79:16];
		return sat_sm((a < 0) != (b < 0), m);
	endfunction

	function automatic longint q_div(longint a, longint b, inout logic divz);
		logic [127:0] n;
		logic [63:0] ua, ub;
		if (b == 0) begin
			divz = 1'b1;
			return a > 0 ? 64'sh7fffffffffffffff : (a < 0 ? 64'sh8000000000000000 : 64'sd0);
		end
		ua = mag(a);
		ub = mag(b);
		if (ua / ub >= 64'd1 << 48)
			return sat_sm((a < 0) != (b < 0), '1);
		n = {48'd0, ua, 16'd0} / {64'd0, ub};
		return sat_sm((a < 0) != (b < 0), n[63:0]);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] r, t;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// predicts the output of one particle and updates the local frame flag
	function automatic conv_out_t convert_particle(particle_t p);
		conv_out_t r;
		longint x, y, lg, ux, uy, g, rcp, s, arg, beta, f;
		logic divz, rootz;
		x = longint'(p.x); y = longint'(p.y); lg = longint'(p.lg);
		ux = longint'(ux_q); uy = longint'(uy_q); g = longint'(gamma_q);
		divz = 1'b0; rootz = 1'b0;
		r.conv = p.to_z ? !frame_z_q : frame_z_q;
		if (r.conv) begin
			rcp = q_div(ONE_Q, sat_sum(g, longint'(p.e), 1'b1), divz);
			s = sat_sum(sat_sum(ONE_Q, q_mul(longint'(p.xp), longint'(p.xp)), 1'b0),
				q_mul(longint'(p.yp), longint'(p.yp)), 1'b0);
			arg = sat_sum(ONE_Q, q_mul(q_mul(rcp, rcp), s), 1'b1);
			if (arg < 0) begin
				arg = 64'sd0;
				rootz = 1'b1;
			end
			beta = longint'(floor_sqrt(64'(arg) << 16));
			f = sat_sum(64'sd0, q_div(q_mul(g, beta), ux, divz), 1'b1);
			if (p.to_z) begin
				x = q_mul(x, ux);
				y = q_mul(y, uy);
				lg = q_div(lg, f, divz);
			end else begin
				x = q_div(x, ux, divz);
				y = q_div(y, uy, divz);
				lg = q_mul(lg, f);
			end
			if (p.last)
				frame_z_q = !frame_z_q;
		end
		r.x = clip32(x);
		r.y = clip32(y);
		r.lg = clip32(lg);
		r.fault = divz ? pfc_pkg::FAULT_DIVZ
			: (rootz ? pfc_pkg::FAULT_ROOT : pfc_pkg::FAULT_NONE);
		r.last = p.last;
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[particle_frame_converter_unit] ERROR");
			$finish;
		end
	end

	// receiver side: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_gap);
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		conv_out_t e;
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("output transfer with no particle pending");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$error("pos_x_out exp %h got %h", e.x, m_tdata[31:0]); errors++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$error("pos_y_out exp %h got %h", e.y, m_tdata[63:32]); errors++;
				end
				if (m_tdata[95:64] !== e.lg) begin
					$error("pos_long_out exp %h got %h", e.lg, m_tdata[95:64]); errors++;
				end
				if (m_tuser[0] !== e.conv) begin
					$error("converted exp %b got %b", e.conv, m_tuser[0]); errors++;
				end
				if (m_tuser[2:1] !== e.fault) begin
					$error("fault exp %0d got %0d", e.fault, m_tuser[2:1]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_out exp %b got %b", e.last, m_tlast); errors++;
				end
			end
		end
	end

	task automatic send_particle(particle_t p);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.e, p.lg, p.yp, p.y, p.xp, p.x};
		s_tuser <= p.to_z;
		s_tlast <= p.last;
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(convert_particle(p));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(pfc_pkg::reg_idx_t idx, logic [30:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			pfc_pkg::REG_UNIT_X: ux_q = val;
			pfc_pkg::REG_UNIT_Y: uy_q = val;
			default:             gamma_q = val;
		endcase
	endtask

	function automatic particle_t mk(logic to_z, int x, int xp, int y, int yp, int lg, int e,
			logic last);
		particle_t p;
		p.to_z = to_z; p.x = x; p.xp = xp; p.y = y; p.yp = yp; p.lg = lg; p.e = e;
		p.last = last;
		return p;
	endfunction

	function automatic particle_t rand_particle(logic wild);
		particle_t p;
		p.to_z = 1'($urandom_range(0, 1));
		p.last = ($urandom_range(0, 7) == 0);
		p.x = $urandom;
		p.y = $urandom;
		p.lg = $urandom;
		if (wild) begin
			p.xp = $urandom; p.yp = $urandom; p.e = $urandom;
		end else begin
			p.xp = $signed($urandom_range(0, 8191)) - 4096;
			p.yp = $signed($urandom_range(0, 8191)) - 4096;
			p.e = $signed($urandom_range(0, 32767)) - 16384;
			if ($urandom_range(0, 1)) begin
				p.x = $signed(p.x) >>> 12; p.y = $signed(p.y) >>> 12; p.lg = $signed(p.lg) >>> 12;
			end
		end
		return p;
	endfunction

	// pass-through in the current frame, then one batch each way, with a pass-through between
	task automatic test_frames;
		send_particle(mk(1, 32'sh7fffffff, 0, 32'sh80000000, 0, 65536, 0, 1));
		send_particle(mk(0, 65536, 4096, -65536, -4096, 32'sh7fffffff, 16384, 0));
		send_particle(mk(0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, -16384, 1));
		send_particle(mk(0, 1, 0, -1, 0, 100, 0, 1));
		send_particle(mk(1, -1, 1000, 1, -1000, -100, 2000, 0));
		send_particle(mk(1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 1));
		drain();
	endtask

	// energy equal to gamma, negative root argument and zero beta
	task automatic test_faults;
		write_reg(pfc_pkg::REG_REF_GAMMA, 31'd655360);
		send_particle(mk(0, 65536, 0, 65536, 0, 65536, 655360, 0));
		send_particle(mk(0, 65536, 32'sh7fffffff, 65536, 0, 65536, 0, 0));
		send_particle(mk(0, 65536, 0, 65536, 0, 0, 655360, 1));
		send_particle(mk(1, 65536, 200000, 65536, 0, 65536, 0, 0));
		send_particle(mk(1, 65536, 0, 65536, 0, -65536, 655360, 0));
		send_particle(mk(1, 65536, 0, 65536, 0, 0, 655360, 1));
		drain();
	endtask

	task automatic test_registers;
		logic [30:0] vals[4] = '{31'd1, 31'h7fffffff, 31'd0, 31'd98304};
		foreach (vals[i]) begin
			write_reg(pfc_pkg::REG_UNIT_X, vals[i]);
			write_reg(pfc_pkg::REG_UNIT_Y, vals[(i + 1) % 4]);
			write_reg(pfc_pkg::REG_REF_GAMMA, (i % 2) ? 31'h7fffffff : 31'd65536);
			repeat (4) send_particle(rand_particle(0));
			send_particle(mk(!frame_z_q, 32'sh12345, 3000, -32'sh2345, 100, 32'sh777, 50, 1));
			drain();
		end
	endtask

	task automatic test_random(int n, logic quiet);
		max_gap = quiet ? 0 : 15;
		repeat (n) send_particle(rand_particle($urandom_range(0, 3) == 0));
		drain();
		max_gap = 15;
	endtask

	task automatic test_backpressure;
		max_gap = 0;
		hold_len = 600;
		repeat (350) send_particle(rand_particle(0));
		drain();
		max_gap = 15;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frames();
		test_faults();
		test_registers();
		write_reg(pfc_pkg::REG_UNIT_X, 31'd131072);
		write_reg(pfc_pkg::REG_UNIT_Y, 31'd32768);
		write_reg(pfc_pkg::REG_REF_GAMMA, 31'd327680);
		test_random(300, 0);
		test_random(100, 1);
		test_backpressure();
		write_reg(pfc_pkg::REG_REF_GAMMA, 31'd70000);
		test_random(100, 0);
		if (errors == 0)
			$display("[particle_frame_converter_unit] OK");
		else
			$display("[particle_frame_converter_unit] ERROR");
		$finish;
	end
endmodule
